// ===== hw/rtl/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the sweep position tracker.
// ----------------------------------------------------------------------------
package spt_pkg;

  // default sizes
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  // reset values of state and registers
  localparam int WIDTH_RESET = 2000000;
  localparam logic [15:0] LEAD_RESET = 16'd11565;
  localparam logic [15:0] GAIN_RESET = 16'd55706;
  localparam logic [16:0] OVER_RESET = 17'd77101;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEAD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVER = 2'd2;

  // fixed-point scaling
  localparam int FACTOR_BITS = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam int CHUNK_BITS  = 16;

  // normalized output, Q2.14
  localparam int OUT_BITS  = 16;
  localparam int NORM_FRAC = 14;
  localparam int QUOT_BITS = 17;
  localparam int PRE_SHIFT = QUOT_BITS - NORM_FRAC;
  localparam logic [QUOT_BITS-1:0] QUOT_POS_MAX = 17'd32767;
  localparam logic [QUOT_BITS-1:0] QUOT_NEG_MAX = 17'd32768;
  localparam logic [OUT_BITS-1:0]  NORM_MAX     = 16'h7FFF;
  localparam logic [OUT_BITS-1:0]  NORM_MIN     = 16'h8000;

  // turn codes
  localparam logic [1:0] TURN_NONE = 2'd0;
  localparam logic [1:0] TURN_UP   = 2'd1;
  localparam logic [1:0] TURN_DOWN = 2'd2;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_LEAD = 2'd0,
    MUL_GAIN = 2'd1,
    MUL_OVER = 2'd2
  } mul_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load_sample;
    logic     upd_pos;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     apply_lead;
    logic     apply_gain;
    logic     apply_over;
    logic     div_start;
    logic     out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic turn_up;
    logic turn_down;
    logic mul_done;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/spt_mul.sv =====
// ----------------------------------------------------------------------------
// spt_mul
// Serial fixed-point scaler: (mag * factor + 2^15) >> 16, one 16-bit slice
// of the magnitude per cycle, most significant slice first.
// ----------------------------------------------------------------------------
module spt_mul #(
  parameter int MAG_BITS = spt_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [MAG_BITS-1:0]              mag_i,
  input  logic [spt_pkg::FACTOR_BITS-1:0]  factor_i,
  output logic                             done_o,
  output logic [MAG_BITS:0]                result_o
);

  localparam int CH   = spt_pkg::CHUNK_BITS;
  localparam int FB   = spt_pkg::FACTOR_BITS;
  localparam int NCH  = (MAG_BITS + CH - 1) / CH;
  localparam int PAD  = NCH * CH;
  localparam int ACC  = PAD + FB;
  localparam int CW   = $clog2(NCH + 1);
  localparam int PB   = CH + FB;

  logic [PAD-1:0] mag_q;
  logic [FB-1:0]  f_q;
  logic [ACC-1:0] acc_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [PB-1:0]  prod;
  logic [ACC:0]   rnd;

  // one slice product per cycle
  assign prod = PB'(mag_q[PAD-1 -: CH]) * PB'(f_q);

  // round half up on the final sum
  assign rnd      = {1'b0, acc_q} + (ACC + 1)'(2 ** (spt_pkg::FRAC_SHIFT - 1));
  assign result_o = rnd[spt_pkg::FRAC_SHIFT +: MAG_BITS + 1];
  assign done_o   = done_q;

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NCH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= PAD'(mag_i);
      f_q   <= factor_i;
      acc_q <= '0;
    end else if (busy_q) begin
      mag_q <= mag_q << CH;
      acc_q <= (acc_q << CH) + ACC'(prod);
    end
  end

endmodule

// ===== hw/rtl/spt_div.sv =====
// ----------------------------------------------------------------------------
// spt_div
// Restoring divider for (mag << 14) / den, one quotient bit per cycle,
// with a flag when the quotient would not fit in 17 bits.
// ----------------------------------------------------------------------------
module spt_div #(
  parameter int DEN_BITS = spt_pkg::POSITION_BITS_DEF - 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DEN_BITS:0]              mag_i,
  input  logic [DEN_BITS-1:0]            den_i,
  output logic                           done_o,
  output logic                           ovf_o,
  output logic [spt_pkg::QUOT_BITS-1:0]  quot_o
);

  localparam int QB  = spt_pkg::QUOT_BITS;
  localparam int PRE = spt_pkg::PRE_SHIFT;
  localparam int NF  = spt_pkg::NORM_FRAC;
  localparam int CW  = $clog2(QB + 1);
  localparam int OW  = DEN_BITS + PRE + 1;

  logic [DEN_BITS-1:0] rem_q;
  logic [DEN_BITS-1:0] den_q;
  logic [QB-1:0]       dq_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q;
  logic                done_q;
  logic                ovf_q;
  logic [DEN_BITS:0]   trial;
  logic                ge;

  // quotient of 2^17 or more
  logic ovf_now;
  assign ovf_now = OW'(mag_i) >= OW'({den_i, {PRE{1'b0}}});

  // trial subtract
  assign trial = {rem_q, dq_q[QB-1]};
  assign ge    = trial >= {1'b0, den_q};

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = dq_q;

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_BITS'(mag_i >> PRE);
      dq_q  <= {mag_i[PRE-1:0], {NF{1'b0}}};
      den_q <= den_i;
      ovf_q <= ovf_now;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_BITS'(trial - {1'b0, den_q}) : DEN_BITS'(trial);
      dq_q  <= {dq_q[QB-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/spt_datapath.sv =====
// ----------------------------------------------------------------------------
// spt_datapath
// Position, width and direction state, configuration registers, the shared
// scaler, the divider and the result register.
// ----------------------------------------------------------------------------
module spt_datapath #(
  parameter int SAMPLE_BITS   = spt_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = spt_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spt_pkg::ctrl_cmd_t                cmd_i,
  output spt_pkg::dp_status_t               status_o,
  input  logic                              cfg_we_i,
  input  logic [spt_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [spt_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic signed [spt_pkg::OUT_BITS-1:0] norm_o,
  output logic                              dir_o,
  output logic [1:0]                        turn_o
);

  localparam int P  = POSITION_BITS;
  localparam int W  = POSITION_BITS - 1;
  localparam int S  = SAMPLE_BITS;
  localparam int FB = spt_pkg::FACTOR_BITS;
  localparam int QB = spt_pkg::QUOT_BITS;
  localparam int OB = spt_pkg::OUT_BITS;

  localparam logic [P-1:0] POS_MAX = {1'b0, {(P - 1){1'b1}}};
  localparam logic [P-1:0] POS_MIN = {1'b1, {(P - 1){1'b0}}};

  logic [15:0]    lead_q;
  logic [15:0]    gain_q;
  logic [FB-1:0]  over_q;
  logic [S-1:0]   sample_q;
  logic           dir_q;
  logic [P-1:0]   pos_q;
  logic [W-1:0]   width_q;
  logic [1:0]     turn_q;
  logic [OB-1:0]  norm_q;
  logic           out_dir_q;
  logic [1:0]     out_turn_q;

  logic           samp_neg;
  logic           samp_pos;
  logic [P:0]     diff;
  logic [P-1:0]   pos_sat;
  logic [P-1:0]   pos_mag;
  logic [P-1:0]   mul_mag;
  logic [FB-1:0]  mul_f;
  logic           mul_done;
  logic [P:0]     mul_res;
  logic [P:0]     scaled;
  logic [P:0]     sum;
  logic [W-1:0]   width_new;
  logic           div_done;
  logic           div_ovf;
  logic [QB-1:0]  quot;
  logic [OB-1:0]  norm_new;

  // turn detection on the held sample
  assign samp_neg = sample_q[S-1];
  assign samp_pos = !sample_q[S-1] && (|sample_q);

  assign status_o.turn_up   = samp_neg && !dir_q;
  assign status_o.turn_down = samp_pos && dir_q;
  assign status_o.mul_done  = mul_done;
  assign status_o.div_done  = div_done;

  // integrate and saturate
  assign diff    = {pos_q[P-1], pos_q} - {{(P + 1 - S){sample_q[S-1]}}, sample_q};
  assign pos_sat = (diff[P] != diff[P-1]) ? (diff[P] ? POS_MIN : POS_MAX) : diff[P-1:0];

  assign pos_mag = pos_q[P-1] ? P'(0) - pos_q : pos_q;

  // scaler operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      spt_pkg::MUL_LEAD: begin
        mul_mag = {1'b0, width_q};
        mul_f   = {1'b0, lead_q};
      end
      spt_pkg::MUL_GAIN: begin
        mul_mag = pos_mag;
        mul_f   = {1'b0, gain_q};
      end
      spt_pkg::MUL_OVER: begin
        mul_mag = {1'b0, width_q};
        mul_f   = over_q;
      end
      default: begin
        mul_mag = '0;
        mul_f   = '0;
      end
    endcase
  end

  spt_mul #(
    .MAG_BITS (P)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .mag_i    (mul_mag),
    .factor_i (mul_f),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // width re-estimate: (width + gain * position) / 2, floored, at least 1
  assign scaled    = pos_q[P-1] ? (P + 1)'(0) - mul_res : mul_res;
  assign sum       = {2'b00, width_q} + scaled;
  assign width_new = (sum[P] || (sum[P:1] == '0)) ? W'(1) : sum[P-1:1];

  spt_div #(
    .DEN_BITS (W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .mag_i   (pos_mag),
    .den_i   (width_q),
    .done_o  (div_done),
    .ovf_o   (div_ovf),
    .quot_o  (quot)
  );

  // signed, saturated Q2.14 result
  always_comb begin
    if (pos_q[P-1]) begin
      norm_new = (div_ovf || quot > spt_pkg::QUOT_NEG_MAX) ? spt_pkg::NORM_MIN
                                                            : OB'(0) - quot[OB-1:0];
    end else begin
      norm_new = (div_ovf || quot > spt_pkg::QUOT_POS_MAX) ? spt_pkg::NORM_MAX
                                                            : quot[OB-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= spt_pkg::LEAD_RESET;
      gain_q <= spt_pkg::GAIN_RESET;
      over_q <= spt_pkg::OVER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spt_pkg::CFG_LEAD: lead_q <= cfg_data_i[15:0];
        spt_pkg::CFG_GAIN: gain_q <= cfg_data_i[15:0];
        spt_pkg::CFG_OVER: over_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b1;
      pos_q   <= '0;
      width_q <= W'(spt_pkg::WIDTH_RESET);
      turn_q  <= spt_pkg::TURN_NONE;
    end else begin
      if (cmd_i.upd_pos) begin
        pos_q <= pos_sat;
        if (status_o.turn_up) begin
          dir_q  <= 1'b1;
          turn_q <= spt_pkg::TURN_UP;
        end else if (status_o.turn_down) begin
          dir_q  <= 1'b0;
          turn_q <= spt_pkg::TURN_DOWN;
        end else begin
          turn_q <= spt_pkg::TURN_NONE;
        end
      end
      if (cmd_i.apply_lead) begin
        pos_q <= P'(0) - mul_res[P-1:0];
      end
      if (cmd_i.apply_gain) begin
        width_q <= width_new;
      end
      if (cmd_i.apply_over) begin
        pos_q <= (mul_res[P] || mul_res[P-1]) ? POS_MAX : mul_res[P-1:0];
      end
    end
  end

  // sample hold and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_i;
    end
    if (cmd_i.out_load) begin
      norm_q     <= norm_new;
      out_dir_q  <= dir_q;
      out_turn_q <= turn_q;
    end
  end

  assign norm_o = norm_q;
  assign dir_o  = out_dir_q;
  assign turn_o = out_turn_q;

endmodule

// ===== hw/rtl/spt_ctrl.sv =====
// ----------------------------------------------------------------------------
// spt_ctrl
// Sequencer for one sample: integrate, turn handling through the shared
// scaler, divide, then hand the result to the output register.
// ----------------------------------------------------------------------------
module spt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_active_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  spt_pkg::dp_status_t status_i,
  output spt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_UPDATE     = 11'b000_0000_0010,
    ST_LEAD_WAIT  = 11'b000_0000_0100,
    ST_GAIN_START = 11'b000_0000_1000,
    ST_GAIN_WAIT  = 11'b000_0001_0000,
    ST_OVER_START = 11'b000_0010_0000,
    ST_OVER_WAIT  = 11'b000_0100_0000,
    ST_DIV_START  = 11'b000_1000_0000,
    ST_DIV_WAIT   = 11'b001_0000_0000,
    ST_FINISH     = 11'b010_0000_0000,
    ST_SPARE      = 11'b100_0000_0000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = spt_pkg::MUL_LEAD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_active_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.upd_pos = 1'b1;
        if (status_i.turn_up) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = spt_pkg::MUL_LEAD;
          state_d         = ST_LEAD_WAIT;
        end else if (status_i.turn_down) begin
          state_d = ST_GAIN_START;
        end else begin
          state_d = ST_DIV_START;
        end
      end
      ST_LEAD_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.apply_lead = 1'b1;
          state_d          = ST_DIV_START;
        end
      end
      ST_GAIN_START: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = spt_pkg::MUL_GAIN;
        state_d         = ST_GAIN_WAIT;
      end
      ST_GAIN_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.apply_gain = 1'b1;
          state_d          = ST_OVER_START;
        end
      end
      ST_OVER_START: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = spt_pkg::MUL_OVER;
        state_d         = ST_OVER_WAIT;
      end
      ST_OVER_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.apply_over = 1'b1;
          state_d          = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/sweep_position_tracker.sv =====
// ----------------------------------------------------------------------------
// sweep_position_tracker
// Integrates gyro rate samples into a sweep position and reports the
// position normalized to the estimated sweep width.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries rate_sample_i and
//   active_i. A transfer with active_i low is dropped with no result;
//   with active_i high it yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): norm_position_o, sweep_dir_o, turn_event_o.
//   The time from input transfer to out_valid_o grows on a turn to
//   direction 1 and more on a turn to direction 0. The 17-step restoring
//   divider sets most of it for a 32-bit position; each scaling by a
//   register works through the operand in 16-bit slices.
//   One sample is in work at a time; the next is taken the cycle after the
//   result enters the output register. A stalled result sits in the
//   output register while the next sample is worked on; that sample waits
//   for it before it is loaded.
//   The configuration channel (cfg_valid_i / cfg_ready_o) is always ready.
//   Reset sets direction 1, position 0, width 2000000 and register defaults.
// ----------------------------------------------------------------------------
module sweep_position_tracker #(
  parameter int SAMPLE_BITS   = spt_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = spt_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       rate_sample_i,
  input  logic                                active_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [spt_pkg::OUT_BITS-1:0] norm_position_o,
  output logic                                sweep_dir_o,
  output logic [1:0]                          turn_event_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spt_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [spt_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  spt_pkg::ctrl_cmd_t  cmd;
  spt_pkg::dp_status_t status;
  logic                cfg_we;

  // configuration transfers are taken at once
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_active_i (active_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spt_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (rate_sample_i),
    .norm_o      (norm_position_o),
    .dir_o       (sweep_dir_o),
    .turn_o      (turn_event_o)
  );

  // an active sample keeps the input side busy on the next cycle
  a_busy_after_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && active_i) |=> in_stall_o)
    else $error("input taken again right after an active sample");

  // a reported turn agrees with the reported direction
  a_turn_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (turn_event_o == spt_pkg::TURN_UP || turn_event_o == spt_pkg::TURN_DOWN))
      |-> (sweep_dir_o == (turn_event_o == spt_pkg::TURN_UP)))
    else $error("turn event and sweep direction disagree");

  // after a turn to direction 1 the position is reloaded at or below zero
  a_lead_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && turn_event_o == spt_pkg::TURN_UP)
      |-> (norm_position_o[spt_pkg::OUT_BITS-1] || norm_position_o == '0))
    else $error("positive position after turn to direction 1");

  // after a turn to direction 0 the position is reloaded at or above zero
  a_over_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && turn_event_o == spt_pkg::TURN_DOWN)
      |-> !norm_position_o[spt_pkg::OUT_BITS-1])
    else $error("negative position after turn to direction 0");

endmodule
